// ===== rtl/sfs_pkg.sv =====
// ----------------------------------------------------------------------------
// sfs_pkg
// Shared types and constants of the sprite frame sequencer.
// ----------------------------------------------------------------------------
package sfs_pkg;

  localparam int MAX_FRAMES  = 1024;
  localparam int FRAME_W     = 11;
  localparam int IDX_W       = 10;
  localparam int PERIOD_W    = 24;
  localparam int ELAPSED_W   = 16;
  localparam int CELLS_W     = 7;
  localparam int SHEET_W     = 13;
  localparam int POS_W       = 12;
  localparam int POS_MAX     = 4095;
  localparam int PRODX_W     = CELLS_W + SHEET_W;
  localparam int PRODY_W     = IDX_W + SHEET_W;

  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 24;

  localparam int QUEUE_DEPTH = 2;

  localparam int DIV_W       = 24;
  localparam int DIV_STEP    = 4;
  localparam int DIV_CYC     = DIV_W / DIV_STEP;
  localparam int DIV_CNT_W   = $clog2(DIV_CYC);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_FRAME_PERIOD = 3'd0,
    REG_LOOP_ENABLE  = 3'd1,
    REG_START_FRAME  = 3'd2,
    REG_END_FRAME    = 3'd3,
    REG_NUM_COLUMNS  = 3'd4,
    REG_NUM_ROWS     = 3'd5,
    REG_SHEET_WIDTH  = 3'd6,
    REG_SHEET_HEIGHT = 3'd7
  } cfg_reg_t;

  typedef struct packed {
    logic [ELAPSED_W-1:0] elapsed;
    logic                 restart;
  } in_item_t;

  typedef struct packed {
    logic [FRAME_W-1:0] frame_number;
    logic [POS_W-1:0]   src_x;
    logic [POS_W-1:0]   src_y;
    logic [SHEET_W-1:0] src_w;
    logic [SHEET_W-1:0] src_h;
  } out_item_t;

  // effective settings: frames clamped, cell counts never zero
  typedef struct packed {
    logic [PERIOD_W-1:0] frame_period;
    logic                loop_enable;
    logic [FRAME_W-1:0]  start_frame;
    logic [FRAME_W-1:0]  end_frame;
    logic [CELLS_W-1:0]  num_columns;
    logic [CELLS_W-1:0]  num_rows;
    logic [SHEET_W-1:0]  sheet_width;
    logic [SHEET_W-1:0]  sheet_height;
  } cfg_t;

endpackage

// ===== rtl/sprite_frame_sequencer.sv =====
// ----------------------------------------------------------------------------
// sprite_frame_sequencer
// Steps a sprite-sheet animation per item and reports the current cell.
// ----------------------------------------------------------------------------
// Input items (elapsed ticks, restart) arrive on in_valid/in_stall/in_data;
// each yields one result item (frame number and sheet rectangle) on
// out_valid/out_stall/out_data. The timer stage queues the new frame number
// of each item it takes; in_stall rises only while the queue is full. The
// geometry unit runs five divisions on one shared divider that retires four
// quotient bits a cycle, one frame at a time: it pops the next frame only
// after the last result is registered. A result waits in the output register
// while out_stall is high; the timer keeps taking items until the queue
// fills. Settings are written on cfg_valid/cfg_ready/cfg_index/cfg_data,
// by the user only while the block is idle; the block does not enforce it.
// Reset: countdown zero, frame one, settings at their defaults.
// ----------------------------------------------------------------------------
module sprite_frame_sequencer
  import sfs_pkg::*;
#(
  parameter int QUEUE_DEPTH_P = QUEUE_DEPTH
)
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  in_item_t              in_data,
  output logic                  out_valid,
  input  logic                  out_stall,
  output out_item_t             out_data,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  logic [PERIOD_W-1:0] period_r;
  logic                loop_r;
  logic [FRAME_W-1:0]  start_r, end_r;
  logic [CELLS_W-1:0]  cols_r, rows_r;
  logic [SHEET_W-1:0]  sw_r, sh_r;
  cfg_t                cfg;

  logic                q_push, q_pop, q_full, q_empty;
  logic [FRAME_W-1:0]  q_wdata, q_rdata;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      period_r <= PERIOD_W'(100000);
      loop_r   <= 1'b1;
      start_r  <= FRAME_W'(1);
      end_r    <= FRAME_W'(1);
      cols_r   <= CELLS_W'(1);
      rows_r   <= CELLS_W'(1);
      sw_r     <= SHEET_W'(64);
      sh_r     <= SHEET_W'(64);
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_reg_t'(cfg_index))
        REG_FRAME_PERIOD: period_r <= cfg_data[PERIOD_W-1:0];
        REG_LOOP_ENABLE:  loop_r   <= cfg_data[0];
        REG_START_FRAME:  start_r  <= cfg_data[FRAME_W-1:0];
        REG_END_FRAME:    end_r    <= cfg_data[FRAME_W-1:0];
        REG_NUM_COLUMNS:  cols_r   <= cfg_data[CELLS_W-1:0];
        REG_NUM_ROWS:     rows_r   <= cfg_data[CELLS_W-1:0];
        REG_SHEET_WIDTH:  sw_r     <= cfg_data[SHEET_W-1:0];
        REG_SHEET_HEIGHT: sh_r     <= cfg_data[SHEET_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    cfg.frame_period = period_r;
    cfg.loop_enable  = loop_r;
    cfg.sheet_width  = sw_r;
    cfg.sheet_height = sh_r;
    cfg.num_columns  = (cols_r == '0) ? CELLS_W'(1) : cols_r;
    cfg.num_rows     = (rows_r == '0) ? CELLS_W'(1) : rows_r;
    if (start_r == '0) begin
      cfg.start_frame = FRAME_W'(1);
    end else if (start_r > FRAME_W'(MAX_FRAMES)) begin
      cfg.start_frame = FRAME_W'(MAX_FRAMES);
    end else begin
      cfg.start_frame = start_r;
    end
    if (end_r == '0) begin
      cfg.end_frame = FRAME_W'(1);
    end else if (end_r > FRAME_W'(MAX_FRAMES)) begin
      cfg.end_frame = FRAME_W'(MAX_FRAMES);
    end else begin
      cfg.end_frame = end_r;
    end
  end

  sfs_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_frame  (q_wdata)
  );

  sfs_queue #(
    .DEPTH (QUEUE_DEPTH_P)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_wdata),
    .pop       (q_pop),
    .pop_data  (q_rdata),
    .full      (q_full),
    .empty     (q_empty)
  );

  sfs_geom u_geom (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg),
    .q_empty   (q_empty),
    .q_frame   (q_rdata),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

// ===== rtl/sfs_front.sv =====
// ----------------------------------------------------------------------------
// sfs_front
// Frame timer: takes items, steps the countdown and frame, queues the frame.
// ----------------------------------------------------------------------------
module sfs_front
  import sfs_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  cfg_t               cfg,
  input  logic               in_valid,
  output logic               in_stall,
  input  in_item_t           in_data,
  input  logic               q_full,
  output logic               q_push,
  output logic [FRAME_W-1:0] q_frame
);

  logic [PERIOD_W-1:0] countdown_r, countdown_nxt;
  logic [FRAME_W-1:0]  frame_r, frame_nxt;
  logic [FRAME_W-1:0]  frame_inc;
  logic [PERIOD_W-1:0] elapsed_ext;
  logic                accept;

  assign accept      = in_valid && !q_full;
  assign in_stall    = q_full;
  assign elapsed_ext = {{(PERIOD_W-ELAPSED_W){1'b0}}, in_data.elapsed};
  assign frame_inc   = frame_r + FRAME_W'(1);

  always_comb begin
    countdown_nxt = countdown_r - elapsed_ext;
    frame_nxt     = frame_r;
    if (in_data.restart) begin
      countdown_nxt = cfg.frame_period;
      frame_nxt     = cfg.start_frame;
    end else if (elapsed_ext >= countdown_r) begin
      countdown_nxt = cfg.frame_period;
      if (frame_inc > cfg.end_frame) begin
        frame_nxt = cfg.loop_enable ? cfg.start_frame : cfg.end_frame;
      end else begin
        frame_nxt = frame_inc;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      countdown_r <= '0;
      frame_r     <= FRAME_W'(1);
    end else if (accept) begin
      countdown_r <= countdown_nxt;
      frame_r     <= frame_nxt;
    end
  end

  assign q_push  = accept;
  assign q_frame = frame_nxt;

endmodule

// ===== rtl/sfs_queue.sv =====
// ----------------------------------------------------------------------------
// sfs_queue
// Short frame-number queue between the timer and the geometry unit.
// ----------------------------------------------------------------------------
module sfs_queue
  import sfs_pkg::*;
#(
  parameter int DEPTH = QUEUE_DEPTH
)
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  input  logic [FRAME_W-1:0] push_data,
  input  logic               pop,
  output logic [FRAME_W-1:0] pop_data,
  output logic               full,
  output logic               empty
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [FRAME_W-1:0] mem [DEPTH];
  logic [AW-1:0]      wr_ptr_r, rd_ptr_r;
  logic [CW-1:0]      count_r;

  assign full     = (count_r == CW'(DEPTH));
  assign empty    = (count_r == '0);
  assign pop_data = mem[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == AW'(DEPTH - 1)) ? '0 : wr_ptr_r + AW'(1);
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == AW'(DEPTH - 1)) ? '0 : rd_ptr_r + AW'(1);
      end
      if (push && !pop) begin
        count_r <= count_r + CW'(1);
      end else if (pop && !push) begin
        count_r <= count_r - CW'(1);
      end
    end
  end

endmodule

// ===== rtl/sfs_div.sv =====
// ----------------------------------------------------------------------------
// sfs_div
// Restoring divider, several quotient bits per cycle.
// ----------------------------------------------------------------------------
module sfs_div
  import sfs_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic [DIV_W-1:0]   dividend,
  input  logic [CELLS_W-1:0] divisor,
  output logic               done,
  output logic [DIV_W-1:0]   quotient,
  output logic [CELLS_W-1:0] remainder
);

  logic                 busy_r;
  logic                 done_r;
  logic [DIV_CNT_W-1:0] cnt_r;
  logic [DIV_W-1:0]     num_r, num_nxt;
  logic [CELLS_W-1:0]   rem_r, rem_nxt;
  logic [CELLS_W-1:0]   div_r;

  always_comb begin
    logic [CELLS_W:0] t;
    num_nxt = num_r;
    rem_nxt = rem_r;
    t       = '0;
    for (int i = 0; i < DIV_STEP; i++) begin
      t       = {rem_nxt, num_nxt[DIV_W-1]};
      num_nxt = {num_nxt[DIV_W-2:0], 1'b0};
      if (t >= {1'b0, div_r}) begin
        rem_nxt    = CELLS_W'(t - {1'b0, div_r});
        num_nxt[0] = 1'b1;
      end else begin
        rem_nxt = t[CELLS_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      num_r <= dividend;
      rem_r <= '0;
      div_r <= divisor;
    end else if (busy_r) begin
      num_r <= num_nxt;
      rem_r <= rem_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + DIV_CNT_W'(1);
        if (cnt_r == DIV_CNT_W'(DIV_CYC - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign done      = done_r;
  assign quotient  = num_r;
  assign remainder = rem_r;

endmodule

// ===== rtl/sfs_geom.sv =====
// ----------------------------------------------------------------------------
// sfs_geom
// Cell geometry: frame to sheet rectangle over a shared divider, output reg.
// ----------------------------------------------------------------------------
module sfs_geom
  import sfs_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  cfg_t               cfg,
  input  logic               q_empty,
  input  logic [FRAME_W-1:0] q_frame,
  output logic               q_pop,
  output logic               out_valid,
  input  logic               out_stall,
  output out_item_t          out_data
);

  typedef enum logic [7:0] {
    S_IDLE = 8'b0000_0001,
    S_COL  = 8'b0000_0010,
    S_W    = 8'b0000_0100,
    S_H    = 8'b0000_1000,
    S_MUL  = 8'b0001_0000,
    S_X    = 8'b0010_0000,
    S_Y    = 8'b0100_0000,
    S_OUT  = 8'b1000_0000
  } geom_state_t;

  geom_state_t        state_r, state_nxt;
  logic [FRAME_W-1:0] frame_r;
  logic [CELLS_W-1:0] col_r;
  logic [IDX_W-1:0]   row_r;
  logic [SHEET_W-1:0] w_r, h_r;
  logic [POS_W-1:0]   x_r;
  logic [POS_W-1:0]   y_r;
  logic [PRODX_W-1:0] prodx_r;
  logic [PRODY_W-1:0] prody_r;
  logic               out_valid_r;
  out_item_t          out_data_r;

  logic               div_start;
  logic [DIV_W-1:0]   div_a;
  logic [CELLS_W-1:0] div_b;
  logic               div_done;
  logic [DIV_W-1:0]   div_q;
  logic [CELLS_W-1:0] div_r;
  logic [POS_W-1:0]   q_sat;
  logic [FRAME_W-1:0] idx_full;
  logic               out_free;

  sfs_div u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (div_start),
    .dividend  (div_a),
    .divisor   (div_b),
    .done      (div_done),
    .quotient  (div_q),
    .remainder (div_r)
  );

  assign idx_full = q_frame - FRAME_W'(1);
  assign q_sat    = (div_q > DIV_W'(POS_MAX)) ? POS_W'(POS_MAX) : div_q[POS_W-1:0];
  assign out_free = !out_valid_r || !out_stall;

  always_comb begin
    state_nxt = state_r;
    q_pop     = 1'b0;
    div_start = 1'b0;
    div_a     = '0;
    div_b     = cfg.num_columns;
    case (state_r)
      S_IDLE: begin
        if (!q_empty) begin
          q_pop     = 1'b1;
          div_start = 1'b1;
          div_a     = {{(DIV_W-IDX_W){1'b0}}, idx_full[IDX_W-1:0]};
          state_nxt = S_COL;
        end
      end
      S_COL: begin
        if (div_done) begin
          div_start = 1'b1;
          div_a     = {{(DIV_W-SHEET_W){1'b0}}, cfg.sheet_width};
          state_nxt = S_W;
        end
      end
      S_W: begin
        if (div_done) begin
          div_start = 1'b1;
          div_a     = {{(DIV_W-SHEET_W){1'b0}}, cfg.sheet_height};
          div_b     = cfg.num_rows;
          state_nxt = S_H;
        end
      end
      S_H: begin
        if (div_done) begin
          state_nxt = S_MUL;
        end
      end
      S_MUL: begin
        div_start = 1'b1;
        div_a     = {{(DIV_W-PRODX_W){1'b0}}, prodx_r};
        state_nxt = S_X;
      end
      S_X: begin
        if (div_done) begin
          div_start = 1'b1;
          div_a     = {{(DIV_W-PRODY_W){1'b0}}, prody_r};
          div_b     = cfg.num_rows;
          state_nxt = S_Y;
        end
      end
      S_Y: begin
        if (div_done) begin
          state_nxt = S_OUT;
        end
      end
      S_OUT: begin
        if (out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      frame_r <= q_frame;
    end
    if (state_r == S_COL && div_done) begin
      col_r <= div_r;
      row_r <= div_q[IDX_W-1:0];
    end
    if (state_r == S_W && div_done) begin
      w_r <= div_q[SHEET_W-1:0];
    end
    if (state_r == S_H && div_done) begin
      h_r     <= div_q[SHEET_W-1:0];
      prodx_r <= PRODX_W'(col_r * cfg.sheet_width);
      prody_r <= PRODY_W'(row_r * cfg.sheet_height);
    end
    if (state_r == S_X && div_done) begin
      x_r <= q_sat;
    end
    if (state_r == S_Y && div_done) begin
      y_r <= q_sat;
    end
    if (state_r == S_OUT && out_free) begin
      out_data_r.frame_number <= frame_r;
      out_data_r.src_x        <= x_r;
      out_data_r.src_y        <= y_r;
      out_data_r.src_w        <= w_r;
      out_data_r.src_h        <= h_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r == S_OUT && out_free) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// ===== test/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// Checks sprite_frame_sequencer against a cycle-free animation predictor.
// ----------------------------------------------------------------------------
// A scoreboard keeps its own countdown, frame and settings, and it updates
// them from the settings writes and the input items that the block accepts.
// For each input item it predicts the frame number and the sheet rectangle.
// Results are compared field by field in order.
// A short directed part covers the extremes of the settings and the inputs.
// It covers restart, zero period, clamped frame bounds, start above end with
// and without looping, zero cell counts, and the saturation of src_x and
// src_y. Random phases follow, each with fresh settings and random gaps on
// both sides. One phase has a long receiver hold-off that fills the block.
// ----------------------------------------------------------------------------
module testbench;
  import sfs_pkg::*;

  localparam int STALL_LIMIT = 5000;
  localparam int HOLD_CYCLES = 400;
  localparam int ITEM_TARGET = 2000;

  class frame_scoreboard;
    bit [PERIOD_W-1:0] period;
    bit                loop_on;
    bit [FRAME_W-1:0]  first_frame;
    bit [FRAME_W-1:0]  last_frame;
    bit [CELLS_W-1:0]  cols;
    bit [CELLS_W-1:0]  rows;
    bit [SHEET_W-1:0]  sheet_w;
    bit [SHEET_W-1:0]  sheet_h;
    bit [25:0]         countdown;
    bit [FRAME_W-1:0]  frame;
    out_item_t         expected_cells[$];
    int                errors;

    function new();
      period      = 100000;
      loop_on     = 1;
      first_frame = 1;
      last_frame  = 1;
      cols        = 1;
      rows        = 1;
      sheet_w     = 64;
      sheet_h     = 64;
      countdown   = 0;
      frame       = 1;
      errors      = 0;
    endfunction

    function void write_reg(cfg_reg_t r, logic [CFG_DATA_W-1:0] d);
      case (r)
        REG_FRAME_PERIOD: period      = d[PERIOD_W-1:0];
        REG_LOOP_ENABLE:  loop_on     = d[0];
        REG_START_FRAME:  first_frame = d[FRAME_W-1:0];
        REG_END_FRAME:    last_frame  = d[FRAME_W-1:0];
        REG_NUM_COLUMNS:  cols        = d[CELLS_W-1:0];
        REG_NUM_ROWS:     rows        = d[CELLS_W-1:0];
        REG_SHEET_WIDTH:  sheet_w     = d[SHEET_W-1:0];
        REG_SHEET_HEIGHT: sheet_h     = d[SHEET_W-1:0];
        default: ;
      endcase
    endfunction

    function bit [FRAME_W-1:0] bound_frame(bit [FRAME_W-1:0] f);
      if (f < 1) return FRAME_W'(1);
      if (f > MAX_FRAMES) return FRAME_W'(MAX_FRAMES);
      return f;
    endfunction

    function void note_update(in_item_t it);
      bit [FRAME_W-1:0] lo, hi;
      bit [FRAME_W:0]   nxt;
      longint unsigned  nc, nr, idx, col, row, x, y, w, h;
      out_item_t        exp_item;
      lo = bound_frame(first_frame);
      hi = bound_frame(last_frame);
      nc = (cols == 0) ? 1 : cols;
      nr = (rows == 0) ? 1 : rows;
      if (it.restart) begin
        countdown = {2'b00, period};
        frame = lo;
      end else if (it.elapsed >= countdown) begin
        nxt = {1'b0, frame} + (FRAME_W+1)'(1);
        countdown = {2'b00, period};
        if (nxt > {1'b0, hi}) nxt = loop_on ? {1'b0, lo} : {1'b0, hi};
        frame = nxt[FRAME_W-1:0];
      end else begin
        countdown = countdown - {10'd0, it.elapsed};
      end
      idx = (frame == 0) ? 0 : frame - 1;
      col = idx % nc;
      row = idx / nc;
      x = (col * sheet_w) / nc;
      y = (row * sheet_h) / nr;
      w = sheet_w / nc;
      h = sheet_h / nr;
      exp_item.frame_number = frame;
      exp_item.src_x = (x > POS_MAX) ? POS_W'(POS_MAX) : x[POS_W-1:0];
      exp_item.src_y = (y > POS_MAX) ? POS_W'(POS_MAX) : y[POS_W-1:0];
      exp_item.src_w = (w > 8191) ? SHEET_W'(8191) : w[SHEET_W-1:0];
      exp_item.src_h = (h > 8191) ? SHEET_W'(8191) : h[SHEET_W-1:0];
      expected_cells.push_back(exp_item);
    endfunction

    function void check_field(string name, logic [SHEET_W-1:0] want,
                              logic [SHEET_W-1:0] got);
      if (got !== want) begin
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
        errors++;
      end
    endfunction

    function void check_cell(out_item_t got);
      out_item_t want;
      if (expected_cells.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual %p", $time, got);
        errors++;
        return;
      end
      want = expected_cells.pop_front();
      check_field("frame_number", want.frame_number, got.frame_number);
      check_field("src_x", want.src_x, got.src_x);
      check_field("src_y", want.src_y, got.src_y);
      check_field("src_w", want.src_w, got.src_w);
      check_field("src_h", want.src_h, got.src_h);
    endfunction

    function int pending();
      return expected_cells.size();
    endfunction
  endclass

  logic                  clk = 0;
  logic                  rst_n = 0;
  logic                  in_valid = 0;
  logic                  in_stall;
  in_item_t              in_data = '0;
  logic                  out_valid;
  logic                  out_stall = 0;
  out_item_t             out_data;
  logic                  cfg_valid = 0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  frame_scoreboard sb;
  int tx_max = 10;
  int rx_max = 10;
  bit hold_req = 0;
  int quiet_cycles = 0;

  sprite_frame_sequencer dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #4 clk = 1;
    #4 clk = 0;
  end

  always @(posedge clk) begin
    if (rst_n && sb != null) begin
      if (cfg_valid && cfg_ready) sb.write_reg(cfg_reg_t'(cfg_index), cfg_data);
      if (in_valid && !in_stall) sb.note_update(in_data);
      if (out_valid && !out_stall) sb.check_cell(out_data);
    end
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles == STALL_LIMIT) begin
        $display("Some tests failed");
        $finish;
      end
    end
  end

  initial begin
    int n;
    forever begin
      if (hold_req) begin
        n = HOLD_CYCLES;
        hold_req = 0;
      end else begin
        n = $urandom_range(0, rx_max);
      end
      if (n > 0) begin
        out_stall <= 1;
        repeat (n) @(posedge clk);
      end
      out_stall <= 0;
      do @(posedge clk); while (!(rst_n && out_valid));
    end
  end

  task automatic send_update(input logic [ELAPSED_W-1:0] el, input logic rs);
    int gap;
    gap = $urandom_range(0, tx_max);
    if (gap > 0) begin
      in_valid <= 0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1;
    in_data.elapsed <= el;
    in_data.restart <= rs;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic wait_drain();
    in_valid <= 0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
  endtask

  task automatic settle();
    wait_drain();
    repeat (64) @(posedge clk);
  endtask

  task automatic apply_config(input logic [CFG_DATA_W-1:0] per, input logic lp,
                              input logic [CFG_DATA_W-1:0] sf, input logic [CFG_DATA_W-1:0] ef,
                              input logic [CFG_DATA_W-1:0] nc, input logic [CFG_DATA_W-1:0] nr,
                              input logic [CFG_DATA_W-1:0] sw, input logic [CFG_DATA_W-1:0] sh);
    logic [CFG_DATA_W-1:0] vals [8];
    cfg_reg_t r;
    vals[REG_FRAME_PERIOD] = per;
    vals[REG_LOOP_ENABLE]  = CFG_DATA_W'(lp);
    vals[REG_START_FRAME]  = sf;
    vals[REG_END_FRAME]    = ef;
    vals[REG_NUM_COLUMNS]  = nc;
    vals[REG_NUM_ROWS]     = nr;
    vals[REG_SHEET_WIDTH]  = sw;
    vals[REG_SHEET_HEIGHT] = sh;
    r = r.first();
    repeat (8) begin
      cfg_valid <= 1;
      cfg_index <= r;
      cfg_data  <= vals[r];
      do @(posedge clk); while (!cfg_ready);
      r = r.next();
    end
    cfg_valid <= 0;
  endtask

  function automatic logic [CFG_DATA_W-1:0] pick_cells();
    case ($urandom_range(0, 7))
      0: return 0;
      1: return 127;
      2: return 64;
      3: return CFG_DATA_W'($urandom_range(0, 127));
      default: return CFG_DATA_W'($urandom_range(1, 8));
    endcase
  endfunction

  function automatic logic [CFG_DATA_W-1:0] pick_sheet();
    case ($urandom_range(0, 7))
      0: return 0;
      1: return 8191;
      2: return 4096;
      3: return CFG_DATA_W'($urandom_range(0, 8191));
      default: return CFG_DATA_W'($urandom_range(1, 4096));
    endcase
  endfunction

  task automatic random_config();
    logic [CFG_DATA_W-1:0] per, sf, ef, tmp;
    case ($urandom_range(0, 9))
      0: per = 0;
      1: per = 1;
      2: per = 24'hFFFFFF;
      3: per = CFG_DATA_W'($urandom);
      default: per = CFG_DATA_W'($urandom_range(1, 4000));
    endcase
    if ($urandom_range(0, 5) == 0) begin
      sf = CFG_DATA_W'($urandom_range(0, 2047));
      ef = CFG_DATA_W'($urandom_range(0, 2047));
    end else begin
      sf = CFG_DATA_W'($urandom_range(1, 40));
      ef = sf + CFG_DATA_W'($urandom_range(0, 20));
      if ($urandom_range(0, 7) == 0) begin
        tmp = sf;
        sf = ef;
        ef = tmp;
      end
    end
    apply_config(per, 1'($urandom_range(0, 1)), sf, ef, pick_cells(), pick_cells(),
                 pick_sheet(), pick_sheet());
  endtask

  initial begin
    int total, phase, count;
    logic [ELAPSED_W-1:0] el;
    sb = new();
    repeat (10) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    send_update(0, 0);
    send_update(16'hFFFF, 0);
    send_update(0, 1);

    settle();
    apply_config(0, 1, 5, 3, 0, 0, 8191, 8191);
    send_update(0, 1);
    send_update(0, 0);
    send_update(100, 0);

    settle();
    apply_config(1, 0, 0, 2047, 64, 64, 8191, 4096);
    send_update(0, 1);
    send_update(0, 0);
    send_update(1, 0);

    settle();
    apply_config(0, 0, 1023, 1024, 64, 64, 8191, 4096);
    send_update(0, 1);
    send_update(0, 0);
    send_update(0, 0);

    settle();
    apply_config(24'hFFFFFF, 1, 2047, 0, 127, 127, 4096, 8191);
    send_update(0, 1);
    send_update(16'hFFFF, 0);
    send_update(16'hFFFF, 0);

    settle();
    apply_config(0, 0, 7, 4, 3, 2, 100, 50);
    send_update(0, 1);
    send_update(0, 0);
    send_update(0, 0);

    total = 0;
    phase = 0;
    while (total < ITEM_TARGET) begin
      settle();
      random_config();
      tx_max = ($urandom_range(0, 3) == 0) ? 0 : 10;
      rx_max = ($urandom_range(0, 3) == 0) ? 0 : 10;
      if (phase == 2) begin
        tx_max = 0;
        hold_req = 1;
      end
      count = $urandom_range(60, 140);
      send_update(ELAPSED_W'($urandom), 1);
      repeat (count - 1) begin
        if ($urandom_range(0, 63) == 0) wait_drain();
        case ($urandom_range(0, 9))
          0: el = 0;
          1: el = 16'hFFFF;
          2, 3: el = ELAPSED_W'($urandom);
          default: el = ELAPSED_W'($urandom_range(0, 1500));
        endcase
        send_update(el, $urandom_range(0, 15) == 0);
      end
      total += count;
      phase++;
    end

    wait_drain();
    repeat (100) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/sfs_pkg.sv
rtl/sfs_front.sv
rtl/sfs_queue.sv
rtl/sfs_div.sv
rtl/sfs_geom.sv
rtl/sprite_frame_sequencer.sv
test/testbench.sv
